// ===== design/e2q_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, types and the arctangent table for the Euler-to-quaternion pipeline.
package e2q_pkg;

    localparam int ANGLE_W = 16;
    localparam int QUAT_W = 16;
    localparam int XY_W = 33;
    localparam int Z_W = 34;
    localparam int TRIG_W = 22;
    localparam int PROD_W = 2 * TRIG_W;
    localparam int SUM_W = PROD_W + 1;
    localparam int Q14_W = SUM_W - 26;
    localparam int ATAN_LEN = 24;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = 33'sd652032874;
    localparam logic signed [XY_W:0] ROUND_Q20 = 34'sd512;
    localparam logic signed [PROD_W:0] ROUND_PAIR = 45'sd524288;
    localparam logic signed [SUM_W:0] ROUND_Q14 = 46'sd33554432;
    localparam logic signed [Q14_W-1:0] Q14_ONE = 19'sd16384;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cosine;
        logic signed [TRIG_W-1:0] sine;
    } trig_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 34'sd843314856;
            5'd1:    val = 34'sd497837829;
            5'd2:    val = 34'sd263043836;
            5'd3:    val = 34'sd133525158;
            5'd4:    val = 34'sd67021686;
            5'd5:    val = 34'sd33543515;
            5'd6:    val = 34'sd16775850;
            5'd7:    val = 34'sd8388437;
            5'd8:    val = 34'sd4194282;
            5'd9:    val = 34'sd2097149;
            5'd10:   val = 34'sd1048575;
            5'd11:   val = 34'sd524287;
            5'd12:   val = 34'sd262143;
            5'd13:   val = 34'sd131071;
            5'd14:   val = 34'sd65535;
            5'd15:   val = 34'sd32767;
            5'd16:   val = 34'sd16383;
            5'd17:   val = 34'sd8191;
            5'd18:   val = 34'sd4095;
            5'd19:   val = 34'sd2047;
            5'd20:   val = 34'sd1023;
            5'd21:   val = 34'sd511;
            5'd22:   val = 34'sd255;
            5'd23:   val = 34'sd127;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== design/e2q_sincos.sv =====
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC giving the cosine and sine of half an input angle.
module e2q_sincos #(
    parameter int STAGES = 16
) (
    input  logic                                 aclk,
    input  logic [STAGES+1:0]                    stage_en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]   angle,
    output e2q_pkg::trig_t                       trig
);

    logic signed [e2q_pkg::XY_W-1:0] x_reg [0:STAGES];
    logic signed [e2q_pkg::XY_W-1:0] y_reg [0:STAGES];
    logic signed [e2q_pkg::Z_W-1:0]  z_reg [0:STAGES];
    e2q_pkg::trig_t                  trig_reg;

    logic signed [e2q_pkg::ANGLE_W-1:0] angle_clamped;
    logic signed [e2q_pkg::Z_W-1:0]     angle_wide;
    logic signed [e2q_pkg::XY_W:0]      x_round;
    logic signed [e2q_pkg::XY_W:0]      y_round;

    always_comb begin
        if (angle > e2q_pkg::ANGLE_LIMIT) begin
            angle_clamped = e2q_pkg::ANGLE_LIMIT;
        end else if (angle < -e2q_pkg::ANGLE_LIMIT) begin
            angle_clamped = -e2q_pkg::ANGLE_LIMIT;
        end else begin
            angle_clamped = angle;
        end
        angle_wide = e2q_pkg::Z_W'(angle_clamped);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            x_reg[0] <= e2q_pkg::CORDIC_GAIN_INV;
            y_reg[0] <= '0;
            z_reg[0] <= angle_wide <<< 16;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        logic signed [e2q_pkg::XY_W-1:0] x_next;
        logic signed [e2q_pkg::XY_W-1:0] y_next;
        logic signed [e2q_pkg::Z_W-1:0]  z_next;
        logic signed [e2q_pkg::Z_W-1:0]  atan_val;

        always_comb begin
            atan_val = e2q_pkg::atan_q30(e2q_pkg::ATAN_IDX_W'(i));
            if (!z_reg[i][e2q_pkg::Z_W-1]) begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - atan_val;
            end else begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + atan_val;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[i+1]) begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    end

    always_comb begin
        x_round = (e2q_pkg::XY_W+1)'(x_reg[STAGES]) + e2q_pkg::ROUND_Q20;
        y_round = (e2q_pkg::XY_W+1)'(y_reg[STAGES]) + e2q_pkg::ROUND_Q20;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[STAGES+1]) begin
            trig_reg.cosine <= x_round[10 +: e2q_pkg::TRIG_W];
            trig_reg.sine   <= y_round[10 +: e2q_pkg::TRIG_W];
        end
    end

    assign trig = trig_reg;

endmodule

// ===== design/e2q_combine.sv =====
`timescale 1ns / 1ps
// Three-stage multiply pipeline that forms the quaternion from the half-angle sines and cosines.
module e2q_combine (
    input  logic                                aclk,
    input  logic [2:0]                          stage_en,
    input  e2q_pkg::trig_t                      roll_trig,
    input  e2q_pkg::trig_t                      pitch_trig,
    input  e2q_pkg::trig_t                      yaw_trig,
    output logic signed [e2q_pkg::QUAT_W-1:0]   quat_w,
    output logic signed [e2q_pkg::QUAT_W-1:0]   quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0]   quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0]   quat_z
);

    logic signed [e2q_pkg::PROD_W-1:0] cc_reg, ss_reg, sc_reg, cs_reg;
    e2q_pkg::trig_t                    yaw_reg;
    logic signed [e2q_pkg::PROD_W-1:0] prod_reg [0:7];
    logic signed [e2q_pkg::QUAT_W-1:0] quat_reg [0:3];

    logic signed [e2q_pkg::PROD_W:0]   cc_sum, ss_sum, sc_sum, cs_sum;
    logic signed [e2q_pkg::TRIG_W-1:0] cc, ss, sc, cs;
    logic signed [e2q_pkg::SUM_W-1:0]  comp_sum [0:3];
    logic signed [e2q_pkg::SUM_W:0]    comp_round [0:3];
    logic signed [e2q_pkg::Q14_W-1:0]  comp_q14 [0:3];
    logic signed [e2q_pkg::QUAT_W-1:0] comp_sat [0:3];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            cc_reg  <= roll_trig.cosine * pitch_trig.cosine;
            ss_reg  <= roll_trig.sine * pitch_trig.sine;
            sc_reg  <= roll_trig.sine * pitch_trig.cosine;
            cs_reg  <= roll_trig.cosine * pitch_trig.sine;
            yaw_reg <= yaw_trig;
        end
    end

    always_comb begin
        cc_sum = (e2q_pkg::PROD_W+1)'(cc_reg) + e2q_pkg::ROUND_PAIR;
        ss_sum = (e2q_pkg::PROD_W+1)'(ss_reg) + e2q_pkg::ROUND_PAIR;
        sc_sum = (e2q_pkg::PROD_W+1)'(sc_reg) + e2q_pkg::ROUND_PAIR;
        cs_sum = (e2q_pkg::PROD_W+1)'(cs_reg) + e2q_pkg::ROUND_PAIR;
        cc = cc_sum[20 +: e2q_pkg::TRIG_W];
        ss = ss_sum[20 +: e2q_pkg::TRIG_W];
        sc = sc_sum[20 +: e2q_pkg::TRIG_W];
        cs = cs_sum[20 +: e2q_pkg::TRIG_W];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_reg[0] <= cc * yaw_reg.cosine;
            prod_reg[1] <= ss * yaw_reg.sine;
            prod_reg[2] <= sc * yaw_reg.cosine;
            prod_reg[3] <= cs * yaw_reg.sine;
            prod_reg[4] <= cs * yaw_reg.cosine;
            prod_reg[5] <= sc * yaw_reg.sine;
            prod_reg[6] <= cc * yaw_reg.sine;
            prod_reg[7] <= ss * yaw_reg.cosine;
        end
    end

    always_comb begin
        comp_sum[0] = e2q_pkg::SUM_W'(prod_reg[0]) + e2q_pkg::SUM_W'(prod_reg[1]);
        comp_sum[1] = e2q_pkg::SUM_W'(prod_reg[2]) - e2q_pkg::SUM_W'(prod_reg[3]);
        comp_sum[2] = e2q_pkg::SUM_W'(prod_reg[4]) + e2q_pkg::SUM_W'(prod_reg[5]);
        comp_sum[3] = e2q_pkg::SUM_W'(prod_reg[6]) - e2q_pkg::SUM_W'(prod_reg[7]);
        for (int k = 0; k < 4; k++) begin
            comp_round[k] = (e2q_pkg::SUM_W+1)'(comp_sum[k]) + e2q_pkg::ROUND_Q14;
            comp_q14[k] = comp_round[k][26 +: e2q_pkg::Q14_W];
            if (comp_q14[k] > e2q_pkg::Q14_ONE) begin
                comp_sat[k] = e2q_pkg::QUAT_W'(e2q_pkg::Q14_ONE);
            end else if (comp_q14[k] < -e2q_pkg::Q14_ONE) begin
                comp_sat[k] = e2q_pkg::QUAT_W'(-e2q_pkg::Q14_ONE);
            end else begin
                comp_sat[k] = e2q_pkg::QUAT_W'(comp_q14[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            for (int k = 0; k < 4; k++) begin
                quat_reg[k] <= comp_sat[k];
            end
        end
    end

    assign quat_w = quat_reg[0];
    assign quat_x = quat_reg[1];
    assign quat_y = quat_reg[2];
    assign quat_z = quat_reg[3];

endmodule

// ===== design/euler_to_quaternion_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Euler-angle (Z-Y-X) to unit-quaternion converter.
// The unit accepts one transaction per clock cycle while the result side is not stalled. Its
// stages are one register stage for the clamped angle, one stage per CORDIC iteration,
// one stage that rounds the sine and cosine, and three multiply stages that form the quaternion,
// the last of them being the output register. Every stage carries its own valid bit and
// moves whenever the stage after it is empty or moving, so empty stages close up while the
// result side is stalled and new transactions are still taken until the pipeline is full.
module euler_to_quaternion_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  s_roll_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  s_pitch_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  s_yaw_angle,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [e2q_pkg::QUAT_W-1:0]   m_quat_w,
    output logic signed [e2q_pkg::QUAT_W-1:0]   m_quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0]   m_quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0]   m_quat_z
);

    localparam int TRIG_DEPTH = CORDIC_STAGES + 2;
    localparam int DEPTH = TRIG_DEPTH + 3;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DEPTH-1:0] stage_en;

    e2q_pkg::trig_t roll_trig;
    e2q_pkg::trig_t pitch_trig;
    e2q_pkg::trig_t yaw_trig;

    assign stage_en[DEPTH-1] = !valid_reg[DEPTH-1] || m_ready;
    for (genvar k = 0; k < DEPTH - 1; k++) begin : g_enable
        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    always_comb begin
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    e2q_sincos #(
        .STAGES(CORDIC_STAGES)
    ) u_roll (
        .aclk     (aclk),
        .stage_en (stage_en[TRIG_DEPTH-1:0]),
        .angle    (s_roll_angle),
        .trig     (roll_trig)
    );

    e2q_sincos #(
        .STAGES(CORDIC_STAGES)
    ) u_pitch (
        .aclk     (aclk),
        .stage_en (stage_en[TRIG_DEPTH-1:0]),
        .angle    (s_pitch_angle),
        .trig     (pitch_trig)
    );

    e2q_sincos #(
        .STAGES(CORDIC_STAGES)
    ) u_yaw (
        .aclk     (aclk),
        .stage_en (stage_en[TRIG_DEPTH-1:0]),
        .angle    (s_yaw_angle),
        .trig     (yaw_trig)
    );

    e2q_combine u_combine (
        .aclk       (aclk),
        .stage_en   (stage_en[DEPTH-1:TRIG_DEPTH]),
        .roll_trig  (roll_trig),
        .pitch_trig (pitch_trig),
        .yaw_trig   (yaw_trig),
        .quat_w     (m_quat_w),
        .quat_x     (m_quat_x),
        .quat_y     (m_quat_y),
        .quat_z     (m_quat_z)
    );

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[DEPTH-1];

    // Input backpressure only arises from a stalled result.
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the result side is free");

    // An accepted transaction occupies the first stage on the next cycle.
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    // A full pipeline that is stalled keeps every stage occupied.
    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg && !m_ready) |=> (&valid_reg))
        else $error("stalled full pipeline dropped a transaction");

    // Every delivered component lies within plus or minus one.
    a_quat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quat_w <= 16'sd16384 && m_quat_w >= -16'sd16384
            && m_quat_x <= 16'sd16384 && m_quat_x >= -16'sd16384
            && m_quat_y <= 16'sd16384 && m_quat_y >= -16'sd16384
            && m_quat_z <= 16'sd16384 && m_quat_z >= -16'sd16384))
        else $error("quaternion component outside the saturation range");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Euler-angle (Z-Y-X) to unit-quaternion converter.
module tb_top;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 5;
    localparam int STALL_LIMIT = 2000;
    localparam int ANGLE_MAX = 25736;

    typedef logic signed [e2q_pkg::ANGLE_W-1:0] angle_t;
    typedef logic signed [e2q_pkg::QUAT_W-1:0] comp_t;

    typedef struct {
        comp_t w;
        comp_t x;
        comp_t y;
        comp_t z;
    } quat_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    angle_t s_roll_angle;
    angle_t s_pitch_angle;
    angle_t s_yaw_angle;
    logic m_valid;
    logic m_ready;
    comp_t m_quat_w;
    comp_t m_quat_x;
    comp_t m_quat_y;
    comp_t m_quat_z;

    quat_t quat_pending[$];
    quat_t oldest_quat;
    int errors = 0;
    int angles_sent = 0;
    int quats_checked = 0;
    int idle_cycles = 0;
    bit src_idle_en = 0;
    bit sink_stall_en = 0;

    euler_to_quaternion_unit #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_roll_angle(s_roll_angle),
        .s_pitch_angle(s_pitch_angle),
        .s_yaw_angle(s_yaw_angle),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_quat_w(m_quat_w),
        .m_quat_x(m_quat_x),
        .m_quat_y(m_quat_y),
        .m_quat_z(m_quat_z)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint arctan_step_q30(input int idx);
        case (idx)
            0:       return 843314856;
            1:       return 497837829;
            2:       return 263043836;
            3:       return 133525158;
            4:       return 67021686;
            5:       return 33543515;
            6:       return 16775850;
            7:       return 8388437;
            8:       return 4194282;
            9:       return 2097149;
            10:      return 1048575;
            11:      return 524287;
            12:      return 262143;
            13:      return 131071;
            14:      return 65535;
            15:      return 32767;
            16:      return 16383;
            17:      return 8191;
            18:      return 4095;
            19:      return 2047;
            20:      return 1023;
            21:      return 511;
            22:      return 255;
            23:      return 127;
            default: return 0;
        endcase
    endfunction

    function automatic longint clamp_angle(input angle_t raw);
        longint a;
        a = longint'(raw);
        if (a > ANGLE_MAX) begin
            a = ANGLE_MAX;
        end
        if (a < -ANGLE_MAX) begin
            a = -ANGLE_MAX;
        end
        return a;
    endfunction

    // Rotation-mode CORDIC on the half angle; cosine and sine come back in Q20.
    function automatic void half_angle_trig(input longint a, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = 652032874;
        y = 0;
        z = a * 65536;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_step_q30(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_step_q30(i);
            end
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
    endfunction

    function automatic longint pair_product_q20(input longint a, input longint b);
        return (a * b + 524288) >>> 20;
    endfunction

    function automatic comp_t saturate_q14(input longint v40);
        longint r;
        r = (v40 + 33554432) >>> 26;
        if (r > 16384) begin
            r = 16384;
        end
        if (r < -16384) begin
            r = -16384;
        end
        return comp_t'(r);
    endfunction

    function automatic quat_t predict_quat(input angle_t roll, input angle_t pitch,
                                           input angle_t yaw);
        longint cr, sr, cp, sp, cy, sy, cc, ss, sc, cs;
        quat_t q;
        half_angle_trig(clamp_angle(roll), cr, sr);
        half_angle_trig(clamp_angle(pitch), cp, sp);
        half_angle_trig(clamp_angle(yaw), cy, sy);
        cc = pair_product_q20(cr, cp);
        ss = pair_product_q20(sr, sp);
        sc = pair_product_q20(sr, cp);
        cs = pair_product_q20(cr, sp);
        q.w = saturate_q14(cc * cy + ss * sy);
        q.x = saturate_q14(sc * cy - cs * sy);
        q.y = saturate_q14(cs * cy + sc * sy);
        q.z = saturate_q14(cc * sy - ss * cy);
        return q;
    endfunction

    function automatic angle_t random_angle();
        int sel;
        angle_t v;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            v = angle_t'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
        end else if (sel < 8) begin
            v = angle_t'(ANGLE_MAX + int'($urandom_range(0, 6)) - 3);
            if ($urandom_range(0, 1) == 1) begin
                v = -v;
            end
        end else begin
            v = angle_t'($urandom());
        end
        return v;
    endfunction

    task automatic send_angles(input angle_t roll, input angle_t pitch, input angle_t yaw);
        @(negedge aclk);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat (int'($urandom_range(1, 17))) @(negedge aclk);
        end
        s_roll_angle = roll;
        s_pitch_angle = pitch;
        s_yaw_angle = yaw;
        s_valid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        quat_pending.push_back(predict_quat(roll, pitch, yaw));
        angles_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (quat_pending.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic check_component(input string name, input comp_t expected, input comp_t actual);
        if (expected !== actual) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, expected, actual);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (quat_pending.size() == 0) begin
                errors++;
                $error("result transaction with no pending conversion: w=%0d x=%0d y=%0d z=%0d",
                       m_quat_w, m_quat_x, m_quat_y, m_quat_z);
            end else begin
                oldest_quat = quat_pending.pop_front();
                check_component("quat_w", oldest_quat.w, m_quat_w);
                check_component("quat_x", oldest_quat.x, m_quat_x);
                check_component("quat_y", oldest_quat.y, m_quat_y);
                check_component("quat_z", oldest_quat.z, m_quat_z);
                quats_checked++;
            end
        end
    end

    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (sink_stall_en && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat (int'($urandom_range(1, 17))) @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("euler_to_quaternion_unit verification failed");
        $finish;
    end

    // Zero, the range limits, values past them, quarter turns and alternating bit patterns.
    task automatic test_directed();
        send_angles(16'sd0, 16'sd0, 16'sd0);
        send_angles(16'sd25736, 16'sd25736, 16'sd25736);
        send_angles(-16'sd25736, -16'sd25736, -16'sd25736);
        send_angles(16'sd25736, 16'sd0, 16'sd0);
        send_angles(16'sd0, 16'sd25736, 16'sd0);
        send_angles(16'sd0, 16'sd0, 16'sd25736);
        send_angles(-16'sd25736, 16'sd0, 16'sd0);
        send_angles(16'sd0, -16'sd25736, 16'sd0);
        send_angles(16'sd0, 16'sd0, -16'sd25736);
        send_angles(16'sd32767, -16'sd32768, 16'sd25737);
        send_angles(-16'sd25737, 16'sd32767, -16'sd32768);
        send_angles(16'sd12868, 16'sd0, 16'sd0);
        send_angles(16'sd0, 16'sd12868, 16'sd0);
        send_angles(16'sd0, 16'sd0, 16'sd12868);
        send_angles(-16'sd12868, 16'sd12868, -16'sd12868);
        send_angles(16'sd1, -16'sd1, 16'sd1);
        send_angles(-16'sd1, 16'sd1, -16'sd1);
        send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
        send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);
        send_angles(16'sh7FFF, 16'sh7FFF, 16'sh8000);
    endtask

    // Random angles with idle and stall bursts, interleaved with stretches without them.
    task automatic test_random_traffic();
        for (int n = 0; n < 1200; n++) begin
            src_idle_en = ((n / 150) % 3) != 2;
            sink_stall_en = ((n / 100) % 4) != 3;
            send_angles(random_angle(), random_angle(), random_angle());
        end
    endtask

    // The sender holds off until every pending quaternion has been returned.
    task automatic test_drain_pauses();
        int burst;
        src_idle_en = 1'b1;
        sink_stall_en = 1'b1;
        for (int k = 0; k < 6; k++) begin
            burst = $urandom_range(5, 35);
            for (int n = 0; n < burst; n++) begin
                send_angles(random_angle(), random_angle(), random_angle());
            end
            drain_results();
        end
    endtask

    task automatic test_back_to_back();
        src_idle_en = 1'b0;
        sink_stall_en = 1'b0;
        for (int n = 0; n < 450; n++) begin
            send_angles(random_angle(), random_angle(), random_angle());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_roll_angle = '0;
        s_pitch_angle = '0;
        s_yaw_angle = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_traffic();
        test_drain_pauses();
        test_back_to_back();

        drain_results();
        repeat (LATENCY + 8) @(posedge aclk);

        $display("Converted %0d angle triples and checked %0d quaternions,", angles_sent,
                 quats_checked);
        $display("covering range limits, saturated inputs, idle and stall bursts and full rate.");
        if (errors == 0) begin
            $display("euler_to_quaternion_unit verification clean");
        end else begin
            $display("euler_to_quaternion_unit verification failed");
        end
        $finish;
    end

endmodule
